// ===== hdl/multi_channel_soft_timer_bank_unit_defines.svh =====
// Assertion macros for the soft timer bank.
// Clock is clock, reset is reset (synchronous, active high).
`ifndef MULTI_CHANNEL_SOFT_TIMER_BANK_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_SOFT_TIMER_BANK_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define MCSTB_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define MCSTB_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define MCSTB_ASSERT_IMP(label, ante, cons)
`define MCSTB_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hdl/mcstb_pkg.sv =====
package mcstb_pkg;

   // command codes on req_tuser
   localparam logic [2:0] CMD_REGISTER = 3'd0;
   localparam logic [2:0] CMD_PERIOD   = 3'd1;
   localparam logic [2:0] CMD_START    = 3'd2;
   localparam logic [2:0] CMD_STOP     = 3'd3;
   localparam logic [2:0] CMD_CLEAR    = 3'd4;
   localparam logic [2:0] CMD_TICK     = 3'd5;

   // result kinds on rsp_tuser
   localparam logic [1:0] EV_DONE   = 2'd0;
   localparam logic [1:0] EV_EXPIRE = 2'd1;
   localparam logic [1:0] EV_QUIET  = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DUP     = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_UNKNOWN = 2'd3;

   // max expiry results reported per tick
   localparam int RES_CAP = 16;
   localparam int REP_W   = $clog2(RES_CAP + 1);

   typedef enum logic [2:0] {
      OP_REGISTER,
      OP_PERIOD,
      OP_START,
      OP_STOP,
      OP_CLEAR,
      OP_TICK,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  id;
      logic [31:0] period;
      logic        single;
   } cmd_type;

   typedef struct packed {
      logic    vld;
      cmd_type cmd;
   } qhead_type;

endpackage

// ===== hdl/multi_channel_soft_timer_bank_unit.sv =====
// Soft timer bank: up to NUM_SLOTS numbered timers, filled in registration order.
// Commands and ticks enter a two-beat queue; the engine takes one at a time and
// walks the registered slots one per cycle through slot stores with a registered
// read, holding while an expiry beat waits on rsp_tready. A tick pops the command,
// reads each timer, checks for the end of the walk and gives its final result.
// Register walks the registered timers for a duplicate check, stopping just past a
// match, and skips the walk on a full bank, as does an unused command code; the
// other commands stop just past the matching timer. A tick gives one beat per expired
// timer (at most 16, tlast on the final one) or a single no-expiry beat.
`include "multi_channel_soft_timer_bank_unit_defines.svh"

module multi_channel_soft_timer_bank_unit
   import mcstb_pkg::*;
#(
   parameter int NUM_SLOTS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // timer_id[7:0], period_ticks[39:8], one_shot[40], zero pad
   input  logic [2:0]  req_tuser,   // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[1:0], expired_id[9:2], zero pad
   output logic [1:0]  rsp_tuser,   // event_res[1:0]
   output logic        rsp_tlast
);

   qhead_type head;
   logic      pop;

   mcstb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .pop        (pop)
   );

   mcstb_engine #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `MCSTB_ASSERT_IMP(a_pop_nonempty, pop, head.vld)
   `MCSTB_ASSERT_IMP(a_cmd_single_beat, rsp_tvalid && (rsp_tuser == EV_DONE), rsp_tlast)
   `MCSTB_ASSERT_IMP(a_quiet, rsp_tvalid && (rsp_tuser == EV_QUIET), rsp_tlast && (rsp_tdata == '0))
   `MCSTB_ASSERT_NXT(a_pop_takes_head, pop && head.vld && !req_tvalid, !pop)

endmodule

// ===== hdl/mcstb_front.sv =====
module mcstb_front
   import mcstb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // timer_id[7:0], period_ticks[39:8], one_shot[40], zero pad
   input  logic [2:0]  req_tuser,   // command[2:0]
   output qhead_type   head,
   input  logic        pop
);

   cmd_type     q_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  cnt_ff;
   logic        push;
   cmd_type     dec;

   always_comb begin
      dec.id     = req_tdata[7:0];
      dec.period = req_tdata[39:8];
      dec.single = req_tdata[40];
      case (req_tuser)
         CMD_REGISTER: dec.op = OP_REGISTER;
         CMD_PERIOD:   dec.op = OP_PERIOD;
         CMD_START:    dec.op = OP_START;
         CMD_STOP:     dec.op = OP_STOP;
         CMD_CLEAR:    dec.op = OP_CLEAR;
         CMD_TICK:     dec.op = OP_TICK;
         default:      dec.op = OP_NOP;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign head.vld   = (cnt_ff != 2'd0);
   assign head.cmd   = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

// ===== hdl/mcstb_engine.sv =====
module mcstb_engine
   import mcstb_pkg::*;
#(
   parameter int NUM_SLOTS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  qhead_type   head,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[1:0], expired_id[9:2], zero pad
   output logic [1:0]  rsp_tuser,   // event_res[1:0]
   output logic        rsp_tlast
);

   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DONE
   } state_type;

   // slot stores
   logic [7:0]  num_mem    [NUM_SLOTS];
   logic [31:0] per_mem    [NUM_SLOTS];
   logic        single_mem [NUM_SLOTS];
   logic [31:0] cnt_mem    [NUM_SLOTS];
   logic        running_ff [NUM_SLOTS];

   state_type        state_ff;
   cmd_type          cur_ff;
   logic [CNT_W-1:0] next_free_ff;
   logic [CNT_W-1:0] issue_ff;
   logic             s2_vld_ff;
   logic [IDX_W-1:0] s2_idx_ff;
   logic [7:0]       rd_num_ff;
   logic [31:0]      rd_per_ff;
   logic             rd_single_ff;
   logic [31:0]      rd_cnt_ff;
   logic             found_ff;
   logic             full_ff;
   logic             pend_vld_ff;
   logic [7:0]       pend_id_ff;
   logic [REP_W-1:0] rep_ff;

   logic             out_vld_ff;
   logic [1:0]       out_ev_ff;
   logic [1:0]       out_st_ff;
   logic [7:0]       out_id_ff;
   logic             out_last_ff;

   logic             walking;
   logic             out_free;
   logic             is_tick;
   logic             s2_run;
   logic [31:0]      cnt_inc;
   logic             fire;
   logic             hit;
   logic             report;
   logic             emit_need;
   logic             adv;
   logic             iss_ok;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] nf_idx;
   logic             walk_end;
   logic             reg_wr;
   logic             tick_upd;
   logic             act;
   logic [1:0]       fin_st;

   assign walking  = (state_ff == S_WALK);
   assign out_free = !out_vld_ff || rsp_tready;
   assign is_tick  = (cur_ff.op == OP_TICK);
   assign s2_run   = running_ff[s2_idx_ff];
   assign cnt_inc  = rd_cnt_ff + 32'd1;
   assign fire     = (cnt_inc >= rd_per_ff);
   assign hit      = (rd_num_ff == cur_ff.id) && !found_ff;
   assign report   = (rep_ff < REP_W'(RES_CAP));

   // a reported expiry pushes out the one held before it
   assign emit_need = walking && s2_vld_ff && is_tick && s2_run && fire && report && pend_vld_ff;
   assign adv       = !emit_need || out_free;

   assign iss_ok   = (issue_ff < next_free_ff) && !found_ff;
   assign rd_en    = walking && adv && iss_ok;
   assign rd_addr  = issue_ff[IDX_W-1:0];
   assign nf_idx   = next_free_ff[IDX_W-1:0];
   assign walk_end = walking && !s2_vld_ff && !iss_ok;
   assign reg_wr   = walk_end && (cur_ff.op == OP_REGISTER) && !found_ff;
   assign tick_upd = walking && adv && s2_vld_ff && is_tick && s2_run;
   assign act      = walking && adv && s2_vld_ff && !is_tick && hit;

   assign pop = (state_ff == S_IDLE) && head.vld;

   always_comb begin
      case (cur_ff.op)
         OP_REGISTER: fin_st = full_ff ? ST_FULL : (found_ff ? ST_DUP : ST_OK);
         OP_PERIOD,
         OP_START,
         OP_STOP,
         OP_CLEAR:    fin_st = found_ff ? ST_OK : ST_UNKNOWN;
         default:     fin_st = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tick_upd) begin
         cnt_mem[s2_idx_ff] <= fire ? 32'd0 : cnt_inc;
      end else if (act && (cur_ff.op == OP_CLEAR)) begin
         cnt_mem[s2_idx_ff] <= 32'd0;
      end else if (reg_wr) begin
         cnt_mem[nf_idx] <= 32'd0;
      end
      if (rd_en) begin
         rd_cnt_ff <= cnt_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (act && (cur_ff.op == OP_PERIOD)) begin
         per_mem[s2_idx_ff] <= cur_ff.period;
      end else if (reg_wr) begin
         per_mem[nf_idx] <= cur_ff.period;
      end
      if (rd_en) begin
         rd_per_ff <= per_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reg_wr) begin
         num_mem[nf_idx] <= cur_ff.id;
      end
      if (rd_en) begin
         rd_num_ff <= num_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reg_wr) begin
         single_mem[nf_idx] <= cur_ff.single;
      end
      if (rd_en) begin
         rd_single_ff <= single_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_free_ff <= '0;
         issue_ff     <= '0;
         s2_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         full_ff      <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rep_ff       <= '0;
         out_vld_ff   <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            running_ff[i] <= 1'b0;
         end
      end else begin
         if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (head.vld) begin
                  cur_ff      <= head.cmd;
                  issue_ff    <= '0;
                  s2_vld_ff   <= 1'b0;
                  found_ff    <= 1'b0;
                  pend_vld_ff <= 1'b0;
                  rep_ff      <= '0;
                  full_ff     <= (head.cmd.op == OP_REGISTER) &&
                                 (next_free_ff == CNT_W'(NUM_SLOTS));
                  if ((head.cmd.op == OP_NOP) ||
                      ((head.cmd.op == OP_REGISTER) &&
                       (next_free_ff == CNT_W'(NUM_SLOTS)))) begin
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_WALK;
                  end
               end
            end
            S_WALK: begin
               if (adv) begin
                  s2_vld_ff <= rd_en;
                  if (rd_en) begin
                     s2_idx_ff <= rd_addr;
                     issue_ff  <= issue_ff + CNT_W'(1);
                  end
                  if (s2_vld_ff) begin
                     if (is_tick) begin
                        if (s2_run && fire) begin
                           if (rd_single_ff) begin
                              running_ff[s2_idx_ff] <= 1'b0;
                           end
                           if (report) begin
                              pend_vld_ff <= 1'b1;
                              pend_id_ff  <= rd_num_ff;
                              rep_ff      <= rep_ff + REP_W'(1);
                              if (pend_vld_ff) begin
                                 out_vld_ff  <= 1'b1;
                                 out_ev_ff   <= EV_EXPIRE;
                                 out_st_ff   <= ST_OK;
                                 out_id_ff   <= pend_id_ff;
                                 out_last_ff <= 1'b0;
                              end
                           end
                        end
                     end else if (hit) begin
                        found_ff <= 1'b1;
                        case (cur_ff.op)
                           OP_START: running_ff[s2_idx_ff] <= 1'b1;
                           OP_STOP:  running_ff[s2_idx_ff] <= 1'b0;
                           default:  ;
                        endcase
                     end
                  end
               end
               if (walk_end) begin
                  if (reg_wr) begin
                     next_free_ff <= next_free_ff + CNT_W'(1);
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  out_vld_ff  <= 1'b1;
                  out_last_ff <= 1'b1;
                  if (is_tick) begin
                     out_ev_ff <= pend_vld_ff ? EV_EXPIRE : EV_QUIET;
                     out_st_ff <= ST_OK;
                     out_id_ff <= pend_vld_ff ? pend_id_ff : 8'd0;
                  end else begin
                     out_ev_ff <= EV_DONE;
                     out_st_ff <= fin_st;
                     out_id_ff <= cur_ff.id;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'd0, out_id_ff, out_st_ff};
   assign rsp_tuser  = out_ev_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
